>>> src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define TBF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define TBF_ASSERT(label, clk, rst, prop)

`define TBF_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> src/tbf_pkg.sv
// shared types, constants and helper functions of the tagged byte fifo
// no dependencies; imported by the csr, core and top modules of the block
package tbf_pkg;

   localparam int DEPTH      = 16;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int TRIG_W     = 8;
   localparam int RAM_W      = 2 * BYTE_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [BYTE_W-1:0]    ZERO_BYTE     = 8'h00;
   localparam logic [TRIG_W-1:0]    TRIGGER_RESET = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER   = 1'd0;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_RESET = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] write_data;
      logic [BYTE_W-1:0] write_tag;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic overrun;
      logic ready;
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic [BYTE_W-1:0] read_tag;
      status_type        status;
      status_type        changed;
   } result_type;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [RAM_W-1:0] wdata;
      logic [PTR_W-1:0] raddr;
   } ram_ctl_type;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   // equal pointers are ambiguous, the full bit settles it
   function automatic logic [CNT_W-1:0] fill_count(input logic [PTR_W-1:0] wr,
                                                   input logic [PTR_W-1:0] rd,
                                                   input logic             full);
      logic [CNT_W-1:0] cnt;
      if (wr == rd) begin
         cnt = full ? CNT_W'(DEPTH) : '0;
      end else if (wr > rd) begin
         cnt = CNT_W'(wr) - CNT_W'(rd);
      end else begin
         cnt = CNT_W'(wr) + CNT_W'(DEPTH) - CNT_W'(rd);
      end
      return cnt;
   endfunction

endpackage

>>> src/tbf_ram.sv
// generic single write port ram with registered read, write-first on collision
// no dependencies
module tbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] rdata_in;

   // same-cycle write to the read address forwards the new word
   assign rdata_in = (we && (waddr == raddr)) ? wdata : mem_ff[raddr];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= rdata_in;
   end

   assign rdata = rdata_ff;

endmodule

>>> src/tbf_csr.sv
// apb-style register port holding the trigger level
// depends on tbf_pkg
module tbf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tbf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tbf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tbf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [tbf_pkg::TRIG_W-1:0]         trigger
);
   import tbf_pkg::*;

   logic [TRIG_W-1:0]    trigger_ff;
   logic [TRIG_W-1:0]    trigger_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      trigger_in = trigger_ff;
      if (wr_en && (reg_idx == CSR_TRIGGER)) begin
         trigger_in = pwdata[TRIG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff <= TRIGGER_RESET;
      end else begin
         trigger_ff <= trigger_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_TRIGGER) begin
         prdata = CSR_DATA_W'(trigger_ff);
      end
   end

   assign trigger = trigger_ff;

endmodule

>>> src/tbf_core.sv
// queue pointers, status flags and the per-transaction update logic
// depends on tbf_pkg; drives the write and read ports of the entry ram
module tbf_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  tbf_pkg::item_type           item,
   input  logic [tbf_pkg::RAM_W-1:0]   ram_rdata,
   input  logic [tbf_pkg::TRIG_W-1:0]  trigger,
   output tbf_pkg::ram_ctl_type        ram_ctl,
   output tbf_pkg::result_type         result,
   output tbf_pkg::status_type         status
);
   import tbf_pkg::*;

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   status_type       stat_ff, stat_in;
   status_type       changed;
   logic [PTR_W-1:0] rd_adv, wr_adv;
   logic [CNT_W-1:0] cnt_after_wr, cnt_after_rd;
   logic [BYTE_W-1:0] rdata, rtag;
   logic             wr_meets;
   logic             ram_we;

   assign rd_adv       = ptr_advance(rd_ptr_ff);
   assign wr_adv       = ptr_advance(wr_ptr_ff);
   assign wr_meets     = (wr_adv == rd_ptr_ff);
   assign cnt_after_wr = fill_count(wr_adv, rd_ptr_ff, wr_meets);
   assign cnt_after_rd = fill_count(wr_ptr_ff, rd_adv, 1'b0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      stat_in   = stat_ff;
      changed   = '0;
      rdata     = ZERO_BYTE;
      rtag      = ZERO_BYTE;
      ram_we    = 1'b0;
      if (fire) begin
         case (item.kind)
            KIND_WRITE: begin
               if (stat_ff.full) begin
                  changed.overrun = !stat_ff.overrun;
                  stat_in.overrun = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  wr_ptr_in = wr_adv;
                  if (wr_meets) begin
                     changed.full = 1'b1;
                     stat_in.full = 1'b1;
                  end
                  changed.empty = stat_ff.empty;
                  stat_in.empty = 1'b0;
                  if (TRIG_W'(cnt_after_wr) >= trigger) begin
                     changed.ready = !stat_ff.ready;
                     stat_in.ready = 1'b1;
                  end
               end
            end
            KIND_READ: begin
               if (!stat_ff.empty) begin
                  rdata        = ram_rdata[BYTE_W-1:0];
                  rtag         = ram_rdata[RAM_W-1:BYTE_W];
                  rd_ptr_in    = rd_adv;
                  changed.full = stat_ff.full;
                  stat_in.full = 1'b0;
                  if (TRIG_W'(cnt_after_rd) < trigger) begin
                     changed.ready = stat_ff.ready;
                     stat_in.ready = 1'b0;
                  end
                  // empty follows the count alone, whatever the trigger level
                  if (cnt_after_rd == '0) begin
                     changed.empty = 1'b1;
                     stat_in.empty = 1'b1;
                  end
               end
            end
            KIND_CLEAR: begin
               changed.overrun = stat_ff.overrun;
               stat_in.overrun = 1'b0;
            end
            KIND_RESET: begin
               rd_ptr_in       = '0;
               wr_ptr_in       = '0;
               stat_in.full    = 1'b0;
               stat_in.empty   = 1'b1;
               stat_in.overrun = 1'b0;
               stat_in.ready   = 1'b0;
               changed         = '1;
            end
            default: begin
               changed = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         stat_ff   <= '{full: 1'b0, empty: 1'b1, overrun: 1'b0, ready: 1'b0};
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         stat_ff   <= stat_in;
      end
   end

   // ram read address tracks the next read pointer so the head entry is ready
   assign ram_ctl.we    = ram_we;
   assign ram_ctl.waddr = wr_ptr_ff;
   assign ram_ctl.wdata = {item.write_tag, item.write_data};
   assign ram_ctl.raddr = rd_ptr_in;

   assign result.read_data = rdata;
   assign result.read_tag  = rtag;
   assign result.status    = stat_in;
   assign result.changed   = changed;
   assign status           = stat_ff;

endmodule

>>> src/tagged_byte_fifo_with_trigger.sv
// tagged byte fifo with trigger level: an accepted transaction passes the input
// register, then the result register, before its result appears
// one transaction per cycle sustained while rsp_stall is low; the head entry is read
// from the ram ahead of use through its registered port
// synchronous reset clears pointers and flags and sets trigger level to 1;
// stored entries are not cleared
`include "assert_macros.svh"

module tagged_byte_fifo_with_trigger (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tbf_pkg::KIND_W-1:0]        req_kind,
   input  logic [tbf_pkg::BYTE_W-1:0]        req_write_data,
   input  logic [tbf_pkg::BYTE_W-1:0]        req_write_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tbf_pkg::BYTE_W-1:0]        rsp_read_data,
   output logic [tbf_pkg::BYTE_W-1:0]        rsp_read_tag,
   output logic                              rsp_is_full,
   output logic                              rsp_is_empty,
   output logic                              rsp_overrun_flag,
   output logic                              rsp_ready_flag,
   output logic                              rsp_full_changed,
   output logic                              rsp_empty_changed,
   output logic                              rsp_overrun_changed,
   output logic                              rsp_ready_changed,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tbf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tbf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tbf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import tbf_pkg::*;

   item_type          item_ff, item_in;
   logic              item_valid_ff, item_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic [TRIG_W-1:0] trigger;
   ram_ctl_type       ram_ctl;
   logic [RAM_W-1:0]  ram_rdata;
   result_type        result;
   status_type        status;

   // the held transaction moves on when the result register is free or draining
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (!req_stall) begin
         item_valid_in = req_valid;
         item_in       = '{kind: kind_type'(req_kind), write_data: req_write_data,
                           write_tag: req_write_tag};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   tbf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .trigger (trigger)
   );

   tbf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   tbf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item_ff),
      .ram_rdata (ram_rdata),
      .trigger   (trigger),
      .ram_ctl   (ram_ctl),
      .result    (result),
      .status    (status)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_read_tag        = rsp_ff.read_tag;
   assign rsp_is_full         = rsp_ff.status.full;
   assign rsp_is_empty        = rsp_ff.status.empty;
   assign rsp_overrun_flag    = rsp_ff.status.overrun;
   assign rsp_ready_flag      = rsp_ff.status.ready;
   assign rsp_full_changed    = rsp_ff.changed.full;
   assign rsp_empty_changed   = rsp_ff.changed.empty;
   assign rsp_overrun_changed = rsp_ff.changed.overrun;
   assign rsp_ready_changed   = rsp_ff.changed.ready;

   `TBF_ASSERT_NEVER(a_full_and_empty, clock, reset, status.full && status.empty)
   `TBF_ASSERT(a_overrun_on_full_write, clock, reset, advance && (item_ff.kind == KIND_WRITE) && status.full |=> status.overrun)
   `TBF_ASSERT(a_empty_read_no_change, clock, reset, advance && (item_ff.kind == KIND_READ) && status.empty |=> $stable(status))
   `TBF_ASSERT(a_held_item_stable, clock, reset, item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))

endmodule

>>> tb/tagged_byte_fifo_with_trigger_tb.sv
// self-checking testbench for the tagged byte fifo with trigger level
// depends on tbf_pkg and the tagged_byte_fifo_with_trigger top level only
// a mirror class predicts every response; directed fill/overrun then random phases
module tagged_byte_fifo_with_trigger_tb;
   import tbf_pkg::*;

   localparam int WATCHDOG_LIMIT = 400;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 92;
   localparam logic [CSR_ADDR_W-1:0] TRIGGER_ADDR = CSR_ADDR_W'(4 * CSR_TRIGGER);

   // keeps its own copy of the queue and flags, owes one response per request
   class byte_queue_mirror;
      logic [BYTE_W-1:0] data_mem [DEPTH];
      logic [BYTE_W-1:0] tag_mem  [DEPTH];
      int         rd_ptr;
      int         wr_ptr;
      int         trigger;
      status_type flags;
      result_type owed[$];
      int errors, checked, full_hits, overruns, ready_rises, empty_reads;

      function new();
         trigger = int'(TRIGGER_RESET);
         clear_queue();
      endfunction

      function void clear_queue();
         rd_ptr = 0;
         wr_ptr = 0;
         flags  = '{full: 1'b0, empty: 1'b1, overrun: 1'b0, ready: 1'b0};
      endfunction

      function int occupancy();
         if (wr_ptr == rd_ptr) return flags.full ? DEPTH : 0;
         return (wr_ptr - rd_ptr + DEPTH) % DEPTH;
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= 10) $display("ERROR: %s", msg);
      endfunction

      function void take_request(kind_type kind, logic [BYTE_W-1:0] wdata,
                                 logic [BYTE_W-1:0] wtag);
         result_type want;
         int         cnt;
         want = '0;
         case (kind)
            KIND_WRITE: begin
               if (flags.full) begin
                  want.changed.overrun = !flags.overrun;
                  flags.overrun = 1'b1;
                  overruns++;
               end else begin
                  data_mem[wr_ptr] = wdata;
                  tag_mem[wr_ptr]  = wtag;
                  wr_ptr = (wr_ptr + 1) % DEPTH;
                  if (wr_ptr == rd_ptr) begin
                     want.changed.full = !flags.full;
                     flags.full = 1'b1;
                     full_hits++;
                  end
                  want.changed.empty = flags.empty;
                  flags.empty = 1'b0;
                  if (occupancy() >= trigger) begin
                     want.changed.ready = !flags.ready;
                     if (!flags.ready) ready_rises++;
                     flags.ready = 1'b1;
                  end
               end
            end
            KIND_READ: begin
               if (flags.empty) begin
                  empty_reads++;
               end else begin
                  want.read_data = data_mem[rd_ptr];
                  want.read_tag  = tag_mem[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % DEPTH;
                  want.changed.full = flags.full;
                  flags.full = 1'b0;
                  cnt = occupancy();
                  if (cnt < trigger) begin
                     want.changed.ready = flags.ready;
                     flags.ready = 1'b0;
                  end
                  // empty follows the count alone, whatever the trigger says
                  if (cnt == 0) begin
                     want.changed.empty = !flags.empty;
                     flags.empty = 1'b1;
                  end
               end
            end
            KIND_CLEAR: begin
               want.changed.overrun = flags.overrun;
               flags.overrun = 1'b0;
            end
            default: begin
               clear_queue();
               want.changed = '{full: 1'b1, empty: 1'b1, overrun: 1'b1, ready: 1'b1};
            end
         endcase
         want.status = flags;
         owed.push_back(want);
      endfunction

      function void check_result(result_type got);
         result_type want;
         string      diff;
         checked++;
         if (owed.size() == 0) begin
            fail($sformatf("response %0d arrived with no request outstanding", checked));
            return;
         end
         want = owed.pop_front();
         diff = "";
         if (got.read_data !== want.read_data)             diff = {diff, " read_data"};
         if (got.read_tag !== want.read_tag)               diff = {diff, " read_tag"};
         if (got.status.full !== want.status.full)         diff = {diff, " is_full"};
         if (got.status.empty !== want.status.empty)       diff = {diff, " is_empty"};
         if (got.status.overrun !== want.status.overrun)   diff = {diff, " overrun_flag"};
         if (got.status.ready !== want.status.ready)       diff = {diff, " ready_flag"};
         if (got.changed.full !== want.changed.full)       diff = {diff, " full_changed"};
         if (got.changed.empty !== want.changed.empty)     diff = {diff, " empty_changed"};
         if (got.changed.overrun !== want.changed.overrun) diff = {diff, " overrun_changed"};
         if (got.changed.ready !== want.changed.ready)     diff = {diff, " ready_changed"};
         if (diff != "") begin
            fail($sformatf({"response %0d wrong in%s: expected data=%02h tag=%02h ",
                            "fevr=%04b chg=%04b, got data=%02h tag=%02h fevr=%04b chg=%04b"},
                           checked, diff, want.read_data, want.read_tag, want.status,
                           want.changed, got.read_data, got.read_tag, got.status,
                           got.changed));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [KIND_W-1:0] req_kind;
   logic [BYTE_W-1:0] req_write_data, req_write_tag;
   logic rsp_valid, rsp_stall;
   logic [BYTE_W-1:0] rsp_read_data, rsp_read_tag;
   logic rsp_is_full, rsp_is_empty, rsp_overrun_flag, rsp_ready_flag;
   logic rsp_full_changed, rsp_empty_changed, rsp_overrun_changed, rsp_ready_changed;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   byte_queue_mirror mirror = new;
   int   items_sent;
   logic req_no_idle = 1'b0;
   logic rsp_no_idle = 1'b0;

   tagged_byte_fifo_with_trigger dut (.*);

   always #2 clock = ~clock;

   function automatic logic [BYTE_W-1:0] random_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic send_item(input kind_type kind, input logic [BYTE_W-1:0] wdata,
                            input logic [BYTE_W-1:0] wtag);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_write_data <= wdata;
      req_write_tag  <= wtag;
      do @(posedge clock); while (req_stall !== 1'b0);
      mirror.take_request(kind, wdata, wtag);
      items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // upper data bits are junk on purpose, only the low byte is the register
   task automatic set_trigger(input int level);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] back;
      word = $urandom();
      word[TRIG_W-1:0] = level[TRIG_W-1:0];
      csr_write(TRIGGER_ADDR, word);
      mirror.trigger = level;
      csr_read(TRIGGER_ADDR, back);
      if (back !== CSR_DATA_W'(level))
         mirror.fail($sformatf("trigger readback %08h, wrote level %0d", back, level));
   endtask

   // only touch the csr once every response is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.owed.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : result_sink
      int         wait_cycles;
      result_type got;
      rsp_stall = 1'b0;
      forever begin
         wait_cycles = rsp_no_idle ? 0 : $urandom_range(0, 4);
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall == 1'b0));
         got.read_data       = rsp_read_data;
         got.read_tag        = rsp_read_tag;
         got.status.full     = rsp_is_full;
         got.status.empty    = rsp_is_empty;
         got.status.overrun  = rsp_overrun_flag;
         got.status.ready    = rsp_ready_flag;
         got.changed.full    = rsp_full_changed;
         got.changed.empty   = rsp_empty_changed;
         got.changed.overrun = rsp_overrun_changed;
         got.changed.ready   = rsp_ready_changed;
         mirror.check_result(got);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && !rsp_stall) || (psel && penable && pready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int                    roll;
      kind_type              kind;
      int                    trig_plan [PHASES];
      int                    write_pct [PHASES];
      logic [CSR_DATA_W-1:0] back;
      trig_plan      = '{1, 0, 5, 17, 255, 8};
      write_pct      = '{60, 70, 45, 65, 55, 60};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_WRITE;
      req_write_data = '0;
      req_write_tag  = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      items_sent     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read(TRIGGER_ADDR, back);
      if (back !== CSR_DATA_W'(TRIGGER_RESET))
         mirror.fail($sformatf("trigger after reset reads %08h", back));
      // ready should rise exactly when the queue fills
      set_trigger(DEPTH);

      send_item(KIND_RESET, 8'h00, 8'h00);
      send_item(KIND_READ, 8'hFF, 8'hFF);    // read from empty
      send_item(KIND_CLEAR, 8'h00, 8'h00);   // nothing to clear
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)      send_item(KIND_WRITE, 8'h00, 8'hFF);
         else if (i == 1) send_item(KIND_WRITE, 8'hFF, 8'h00);
         else             send_item(KIND_WRITE, random_byte(), random_byte());
      end
      send_item(KIND_WRITE, 8'hA5, 8'h5A);   // lost write sets overrun
      send_item(KIND_WRITE, 8'h5A, 8'hA5);   // overrun already sticky
      send_item(KIND_CLEAR, 8'h00, 8'h00);
      send_item(KIND_READ, 8'h00, 8'h00);
      send_item(KIND_READ, 8'h00, 8'h00);
      send_item(KIND_RESET, 8'hFF, 8'hFF);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         req_no_idle = (p == 2) || (p == 4);
         rsp_no_idle = (p == 2);
         set_trigger(p == PHASES - 1 ? $urandom_range(2, DEPTH - 1) : trig_plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)                             kind = KIND_RESET;
            else if (roll < 10)                       kind = KIND_CLEAR;
            else if (roll < 10 + write_pct[p] * 9 / 10) kind = KIND_WRITE;
            else                                      kind = KIND_READ;
            send_item(kind, random_byte(), random_byte());
         end
      end
      wait_drained();
      repeat (4) @(posedge clock);

      if (mirror.owed.size() != 0)
         mirror.fail($sformatf("%0d responses never arrived", mirror.owed.size()));
      $display("ran %0d transactions over %0d trigger levels (0, 1, 5, depth, 17, 255, random)",
               items_sent, PHASES + 1);
      $display("queue filled %0d times, %0d lost writes, %0d ready rises, %0d empty reads, %0d errors",
               mirror.full_hits, mirror.overruns, mirror.ready_rises, mirror.empty_reads,
               mirror.errors);
      if (mirror.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
